>>> src/dat_pkg.sv
// Shared types, constants and helper functions of the delivery acknowledgment tracker.
package dat_pkg;

    localparam int FLIGHT_DEPTH = 32;
    localparam int SEQ_BITS     = 16;
    localparam int PTR_W        = $clog2(FLIGHT_DEPTH);
    localparam int OCC_W        = $clog2(FLIGHT_DEPTH + 1);
    localparam int EXT_W        = SEQ_BITS + 17;

    localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

    localparam logic [1:0] KIND_SEND = 2'd0;
    localparam logic [1:0] KIND_RECV = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;

    localparam logic [2:0] ST_SENT      = 3'd0;
    localparam logic [2:0] ST_NEW       = 3'd1;
    localparam logic [2:0] ST_STALE     = 3'd2;
    localparam logic [2:0] ST_DELIVERED = 3'd3;
    localparam logic [2:0] ST_GAP_FAIL  = 3'd4;
    localparam logic [2:0] ST_TIMEOUT   = 3'd5;
    localparam logic [2:0] ST_QFULL     = 3'd6;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] packet_seq;
        logic        has_acks;
        logic [15:0] ack_start;
        logic [15:0] ack_count;
        logic [31:0] now;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] result_seq;
        logic        last;
        logic [31:0] sent_total;
        logic [31:0] delivered_total;
        logic [31:0] failed_total;
    } result_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic step;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       range_ok;
        logic       step_event;
        logic       step_done;
        logic       pend_valid;
        logic       out_free;
    } stat_t;

    function automatic logic [SEQ_BITS-1:0] seq_from16(input logic [15:0] v);
        logic [SEQ_BITS+15:0] w;
        w = {{SEQ_BITS{1'b0}}, v};
        return w[SEQ_BITS-1:0];
    endfunction

    function automatic logic [15:0] seq_to16(input logic [SEQ_BITS-1:0] s);
        logic [SEQ_BITS+15:0] w;
        w = {16'h0000, s};
        return w[15:0];
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(FLIGHT_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

endpackage

>>> src/dat_item_if.sv
// Input channel interface carrying one tracker event per beat.
interface dat_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] packet_seq;
    logic        has_acks;
    logic [15:0] ack_start;
    logic [15:0] ack_count;
    logic [31:0] now;

    modport source (output valid, kind, packet_seq, has_acks, ack_start, ack_count, now,
                    input ready);
    modport sink (input valid, kind, packet_seq, has_acks, ack_start, ack_count, now,
                  output ready);
endinterface

>>> src/dat_result_if.sv
// Output channel interface carrying one tracker result per beat.
interface dat_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] result_seq;
    logic        last;
    logic [31:0] sent_total;
    logic [31:0] delivered_total;
    logic [31:0] failed_total;

    modport source (output valid, status, result_seq, last, sent_total, delivered_total,
                    failed_total, input ready);
    modport sink (input valid, status, result_seq, last, sent_total, delivered_total,
                  failed_total, output ready);
endinterface

>>> src/dat_ctrl.sv
// Controller state machine that sequences send, receive and tick processing.
module dat_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_ready,
    input  dat_pkg::stat_t stat,
    output dat_pkg::cmd_t  cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_WALK  = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                case (stat.kind)
                    dat_pkg::KIND_SEND: state_next = S_FLUSH;
                    dat_pkg::KIND_RECV: state_next = stat.range_ok ? S_WALK : S_FLUSH;
                    dat_pkg::KIND_TICK: state_next = S_WALK;
                    default:            state_next = S_IDLE;
                endcase
            end
            S_WALK:
            begin
                if (stat.step_done)
                begin
                    state_next = S_FLUSH;
                end
                else if (!(stat.step_event && stat.pend_valid && !stat.out_free))
                begin
                    cmd.step = 1'b1;
                end
            end
            S_FLUSH:
            begin
                if (!stat.pend_valid)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/dat_datapath.sv
// Datapath with the in-flight FIFO, sequence state, counters and result registers.
module dat_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  dat_pkg::item_t   item_in,
    input  logic             cfg_we,
    input  logic [31:0]      cfg_wdata,
    input  dat_pkg::cmd_t    cmd,
    output dat_pkg::stat_t   stat,
    output logic             res_valid,
    input  logic             res_ready,
    output dat_pkg::result_t res_data
);

    localparam int SB = dat_pkg::SEQ_BITS;
    localparam int PW = dat_pkg::PTR_W;
    localparam int OW = dat_pkg::OCC_W;
    localparam int EW = dat_pkg::EXT_W;

    logic [SB-1:0] seq_mem [dat_pkg::FLIGHT_DEPTH];
    logic [31:0]   stamp_mem [dat_pkg::FLIGHT_DEPTH];

    dat_pkg::item_t item_reg;
    logic [31:0]    timeout_reg;
    logic [PW-1:0]  head_reg, head_next, tail_reg;
    logic [OW-1:0]  occ_reg, occ_next;
    logic [SB-1:0]  next_out_reg, next_out_next;
    logic [SB-1:0]  next_exp_reg, next_exp_next;
    logic [31:0]    sent_reg, sent_next;
    logic [31:0]    deliv_reg, deliv_next;
    logic [31:0]    fail_reg, fail_next;
    logic [SB:0]    cur_reg, cur_next;
    logic [SB-1:0]  end_reg, end_next;
    logic [SB-1:0]  head_seq_reg;
    logic [31:0]    head_stamp_reg;

    logic           pend_valid_reg, pend_valid_next;
    logic [2:0]     pend_status_reg;
    logic [SB-1:0]  pend_seq_reg;
    logic [31:0]    pend_sent_reg, pend_deliv_reg, pend_fail_reg;
    logic           out_valid_reg, out_valid_next;
    dat_pkg::result_t out_reg;

    logic [SB-1:0]  pseq, astart;
    logic [EW-1:0]  end_ext;
    logic [SB:0]    h_ext;
    logic [31:0]    age;
    logic           occ_zero, full, out_free;
    logic           done_ack, done_tick, step_event;
    logic           push, pop, ev, load_out;
    logic [2:0]     ev_status;
    logic [SB-1:0]  ev_seq;

    always_comb
    begin
        pseq     = dat_pkg::seq_from16(item_reg.packet_seq);
        astart   = dat_pkg::seq_from16(item_reg.ack_start);
        end_ext  = EW'(astart) + EW'(item_reg.ack_count) - EW'(1);
        h_ext    = {1'b0, head_seq_reg};
        age      = item_reg.now - head_stamp_reg;
        occ_zero = (occ_reg == '0);
        full     = (occ_reg == OW'(dat_pkg::FLIGHT_DEPTH));
        out_free = !out_valid_reg || res_ready;

        done_ack  = occ_zero || (cur_reg > {1'b0, end_reg})
                    || ((h_ext > cur_reg) && (head_seq_reg > end_reg));
        done_tick = occ_zero || (age < timeout_reg);
        if (item_reg.kind == dat_pkg::KIND_RECV)
        begin
            stat.step_done = done_ack;
            step_event     = !done_ack && (h_ext <= cur_reg);
        end
        else
        begin
            stat.step_done = done_tick;
            step_event     = !done_tick;
        end
        stat.kind       = item_reg.kind;
        stat.range_ok   = item_reg.has_acks && (item_reg.ack_count != 16'h0000)
                          && ((end_ext >> SB) == '0);
        stat.step_event = step_event;
        stat.pend_valid = pend_valid_reg;
        stat.out_free   = out_free;
    end

    always_comb
    begin
        push          = 1'b0;
        pop           = 1'b0;
        ev            = 1'b0;
        ev_status     = dat_pkg::ST_SENT;
        ev_seq        = next_out_reg;
        next_out_next = next_out_reg;
        next_exp_next = next_exp_reg;
        sent_next     = sent_reg;
        deliv_next    = deliv_reg;
        fail_next     = fail_reg;
        cur_next      = cur_reg;
        end_next      = end_reg;
        if (cmd.exec)
        begin
            case (item_reg.kind)
                dat_pkg::KIND_SEND:
                begin
                    ev = 1'b1;
                    if (full)
                    begin
                        ev_status = dat_pkg::ST_QFULL;
                    end
                    else
                    begin
                        push          = 1'b1;
                        next_out_next = next_out_reg + SB'(1);
                        sent_next     = sent_reg + 32'd1;
                    end
                end
                dat_pkg::KIND_RECV:
                begin
                    ev     = 1'b1;
                    ev_seq = pseq;
                    if (pseq >= next_exp_reg)
                    begin
                        ev_status     = dat_pkg::ST_NEW;
                        next_exp_next = pseq + SB'(1);
                    end
                    else
                    begin
                        ev_status = dat_pkg::ST_STALE;
                    end
                    cur_next = {1'b0, astart};
                    end_next = end_ext[SB-1:0];
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.step)
        begin
            ev_seq = head_seq_reg;
            if (item_reg.kind == dat_pkg::KIND_RECV)
            begin
                if (h_ext == cur_reg)
                begin
                    ev         = 1'b1;
                    pop        = 1'b1;
                    ev_status  = dat_pkg::ST_DELIVERED;
                    deliv_next = deliv_reg + 32'd1;
                    cur_next   = cur_reg + (SB + 1)'(1);
                end
                else if (h_ext < cur_reg)
                begin
                    ev        = 1'b1;
                    pop       = 1'b1;
                    ev_status = dat_pkg::ST_GAP_FAIL;
                    fail_next = fail_reg + 32'd1;
                end
                else
                begin
                    cur_next = h_ext;
                end
            end
            else
            begin
                ev        = 1'b1;
                pop       = 1'b1;
                ev_status = dat_pkg::ST_TIMEOUT;
                fail_next = fail_reg + 32'd1;
            end
        end

        head_next = pop ? dat_pkg::ptr_inc(head_reg) : head_reg;
        if (push)
        begin
            occ_next = occ_reg + OW'(1);
        end
        else if (pop)
        begin
            occ_next = occ_reg - OW'(1);
        end
        else
        begin
            occ_next = occ_reg;
        end

        load_out        = (ev && pend_valid_reg) || cmd.flush;
        pend_valid_next = ev ? 1'b1 : (cmd.flush ? 1'b0 : pend_valid_reg);
        out_valid_next  = load_out ? 1'b1 : (res_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            seq_mem[tail_reg]   <= next_out_reg;
            stamp_mem[tail_reg] <= item_reg.now;
        end
        if (push && (tail_reg == head_next))
        begin
            head_seq_reg   <= next_out_reg;
            head_stamp_reg <= item_reg.now;
        end
        else
        begin
            head_seq_reg   <= seq_mem[head_next];
            head_stamp_reg <= stamp_mem[head_next];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item_in;
        end
        cur_reg <= cur_next;
        end_reg <= end_next;
        if (ev)
        begin
            pend_status_reg <= ev_status;
            pend_seq_reg    <= ev_seq;
            pend_sent_reg   <= sent_next;
            pend_deliv_reg  <= deliv_next;
            pend_fail_reg   <= fail_next;
        end
        if (load_out)
        begin
            out_reg.status          <= pend_status_reg;
            out_reg.result_seq      <= dat_pkg::seq_to16(pend_seq_reg);
            out_reg.last            <= cmd.flush;
            out_reg.sent_total      <= pend_sent_reg;
            out_reg.delivered_total <= pend_deliv_reg;
            out_reg.failed_total    <= pend_fail_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg    <= dat_pkg::TIMEOUT_RESET;
            head_reg       <= '0;
            tail_reg       <= '0;
            occ_reg        <= '0;
            next_out_reg   <= '0;
            next_exp_reg   <= '0;
            sent_reg       <= '0;
            deliv_reg      <= '0;
            fail_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
            if (push)
            begin
                tail_reg <= dat_pkg::ptr_inc(tail_reg);
            end
            head_reg       <= head_next;
            occ_reg        <= occ_next;
            next_out_reg   <= next_out_next;
            next_exp_reg   <= next_exp_next;
            sent_reg       <= sent_next;
            deliv_reg      <= deliv_next;
            fail_reg       <= fail_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OW'(dat_pkg::FLIGHT_DEPTH))
        else $error("In-flight occupancy exceeds the FIFO depth.");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ev && pend_valid_reg) |-> out_free)
        else $error("A pending result was pushed out while the output register was busy.");

    a_flush_pending: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |-> (pend_valid_reg && out_free))
        else $error("Flush issued without a pending result or a free output register.");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !occ_zero)
        else $error("Pop from an empty in-flight FIFO.");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (occ_reg == $past(occ_reg) + OW'(1)))
        else $error("Push did not raise the occupancy by one.");

endmodule

>>> src/delivery_ack_tracker_top.sv
// Top level of the delivery acknowledgment tracker.
//
// The item channel takes one event per beat: a send (kind 0), a received packet
// with an optional ack range (kind 1) or a timeout tick (kind 2); kind 3 is dropped.
// The result channel gives zero or more beats per event, and the final one has last set.
// Each result carries the running sent, delivered and failed counters after its update.
// The block handles one event at a time: an event is accepted only when the previous
// one has delivered all of its results into the output register.
// A send or a receive without an ack range is accepted, executed and flushed to the
// output register, and the next event is taken after that flush; kind 3 gives no
// result. A receive with an ack range or a tick then walks the FIFO, one step per
// entry popped and one per cursor jump over a gap, since the FIFO head is read
// through one registered port. The last result is held back until the walk has
// ended. The timeout register is written through cfg_we and cfg_wdata; the user
// must write it only while the block is idle, which the block does not enforce.
// Reset empties the FIFO, clears the sequence numbers and counters and sets the
// timeout to 1000 ticks. When the receiver stalls, the walk pauses with one result
// pending and one in the output register, and no beat is lost.
module delivery_ack_tracker_top (
    input  logic        clk,
    input  logic        rst_n,
    dat_item_if.sink    item,
    dat_result_if.source result,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);

    dat_pkg::item_t   item_payload;
    dat_pkg::result_t res_data;
    dat_pkg::cmd_t    cmd;
    dat_pkg::stat_t   stat;
    logic             res_valid;

    assign item_payload.kind       = item.kind;
    assign item_payload.packet_seq = item.packet_seq;
    assign item_payload.has_acks   = item.has_acks;
    assign item_payload.ack_start  = item.ack_start;
    assign item_payload.ack_count  = item.ack_count;
    assign item_payload.now        = item.now;

    dat_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    dat_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_in   (item_payload),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .res_valid (res_valid),
        .res_ready (result.ready),
        .res_data  (res_data)
    );

    assign result.valid           = res_valid;
    assign result.status          = res_data.status;
    assign result.result_seq      = res_data.result_seq;
    assign result.last            = res_data.last;
    assign result.sent_total      = res_data.sent_total;
    assign result.delivered_total = res_data.delivered_total;
    assign result.failed_total    = res_data.failed_total;

endmodule

>>> tb/tb_delivery_ack_tracker_top.sv
// Self-checking testbench of the delivery acknowledgment tracker with its own tracking predictor.
module tb_delivery_ack_tracker_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] KIND_NONE = 2'd3;
    localparam int LIVE = 0;
    localparam int PLAN = 1;
    localparam int QUIET_LIMIT = 20000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 20;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           cfg_we = 1'b0;
    logic [31:0]    cfg_wdata = '0;
    logic           item_valid = 1'b0;
    dat_pkg::item_t drive_item = '0;
    logic           result_ready = 1'b0;

    dat_item_if   item_ch ();
    dat_result_if result_ch ();

    assign item_ch.valid      = item_valid;
    assign item_ch.kind       = drive_item.kind;
    assign item_ch.packet_seq = drive_item.packet_seq;
    assign item_ch.has_acks   = drive_item.has_acks;
    assign item_ch.ack_start  = drive_item.ack_start;
    assign item_ch.ack_count  = drive_item.ack_count;
    assign item_ch.now        = drive_item.now;
    assign result_ch.ready    = result_ready;

    delivery_ack_tracker_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Two copies of the tracker state: LIVE follows accepted beats, PLAN shapes the stimulus.
    logic [15:0] inflight_seq   [2][dat_pkg::FLIGHT_DEPTH];
    logic [31:0] inflight_stamp [2][dat_pkg::FLIGHT_DEPTH];
    int          rd_ptr       [2];
    int          wr_ptr       [2];
    int          inflight_cnt [2];
    logic [15:0] next_tx_seq  [2];
    logic [15:0] next_rx_seq  [2];
    logic [31:0] sent_cnt     [2];
    logic [31:0] deliv_cnt    [2];
    logic [31:0] fail_cnt     [2];
    logic [31:0] timeout_ticks[2];

    dat_pkg::item_t   event_queue[$];
    dat_pkg::result_t awaited_results[$];

    logic [31:0] clock_ticks = '0;
    bit  beat_taken = 1'b0;
    bit  hold_go = 1'b0;
    int  hold_left = HOLD_CYCLES;
    int  send_idle_pct = 10;
    int  recv_stall_pct = 64;
    int  error_count = 0;
    int  quiet_cycles = 0;
    int  events_taken = 0;
    int  beats_checked = 0;
    int  status_seen[8];

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void stage_result(input int side, input logic [2:0] status,
                                         input logic [15:0] seq,
                                         inout dat_pkg::result_t held,
                                         inout bit have_held);
        if (have_held && side == LIVE)
        begin
            awaited_results.push_back(held);
        end
        held.status          = status;
        held.result_seq      = seq;
        held.last            = 1'b0;
        held.sent_total      = sent_cnt[side];
        held.delivered_total = deliv_cnt[side];
        held.failed_total    = fail_cnt[side];
        have_held = 1'b1;
    endfunction

    function automatic void track_event(input int side, input dat_pkg::item_t ev);
        dat_pkg::result_t held;
        bit               have_held;
        bit               walking;
        logic [15:0]      hd_seq;
        logic [31:0]      age;
        int               range_end;
        int               cursor;
        held = '0;
        have_held = 1'b0;
        case (ev.kind)
            dat_pkg::KIND_SEND:
            begin
                if (inflight_cnt[side] >= dat_pkg::FLIGHT_DEPTH)
                begin
                    stage_result(side, dat_pkg::ST_QFULL, next_tx_seq[side], held, have_held);
                end
                else
                begin
                    inflight_seq[side][wr_ptr[side]]   = next_tx_seq[side];
                    inflight_stamp[side][wr_ptr[side]] = ev.now;
                    wr_ptr[side] = (wr_ptr[side] + 1) % dat_pkg::FLIGHT_DEPTH;
                    inflight_cnt[side]++;
                    sent_cnt[side]++;
                    stage_result(side, dat_pkg::ST_SENT, next_tx_seq[side], held, have_held);
                    next_tx_seq[side]++;
                end
            end
            dat_pkg::KIND_RECV:
            begin
                if (ev.packet_seq >= next_rx_seq[side])
                begin
                    next_rx_seq[side] = ev.packet_seq + 16'd1;
                    stage_result(side, dat_pkg::ST_NEW, ev.packet_seq, held, have_held);
                end
                else
                begin
                    stage_result(side, dat_pkg::ST_STALE, ev.packet_seq, held, have_held);
                end
                range_end = int'(ev.ack_start) + int'(ev.ack_count) - 1;
                if (ev.has_acks && ev.ack_count != 16'd0 && range_end <= 65535)
                begin
                    cursor = int'(ev.ack_start);
                    while (cursor <= range_end && inflight_cnt[side] > 0)
                    begin
                        hd_seq = inflight_seq[side][rd_ptr[side]];
                        if (int'(hd_seq) > cursor)
                        begin
                            cursor = int'(hd_seq);
                        end
                        else
                        begin
                            rd_ptr[side] = (rd_ptr[side] + 1) % dat_pkg::FLIGHT_DEPTH;
                            inflight_cnt[side]--;
                            if (int'(hd_seq) == cursor)
                            begin
                                deliv_cnt[side]++;
                                stage_result(side, dat_pkg::ST_DELIVERED, hd_seq, held,
                                             have_held);
                                cursor++;
                            end
                            else
                            begin
                                fail_cnt[side]++;
                                stage_result(side, dat_pkg::ST_GAP_FAIL, hd_seq, held,
                                             have_held);
                            end
                        end
                    end
                end
            end
            dat_pkg::KIND_TICK:
            begin
                walking = 1'b1;
                while (walking && inflight_cnt[side] > 0)
                begin
                    age = ev.now - inflight_stamp[side][rd_ptr[side]];
                    if (age >= timeout_ticks[side])
                    begin
                        hd_seq = inflight_seq[side][rd_ptr[side]];
                        rd_ptr[side] = (rd_ptr[side] + 1) % dat_pkg::FLIGHT_DEPTH;
                        inflight_cnt[side]--;
                        fail_cnt[side]++;
                        stage_result(side, dat_pkg::ST_TIMEOUT, hd_seq, held, have_held);
                    end
                    else
                    begin
                        walking = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (have_held && side == LIVE)
        begin
            held.last = 1'b1;
            awaited_results.push_back(held);
        end
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    function automatic dat_pkg::item_t make_event(input logic [1:0] kind,
                                                  input logic [15:0] pseq,
                                                  input logic has_acks,
                                                  input logic [15:0] start,
                                                  input logic [15:0] count,
                                                  input logic [31:0] now);
        dat_pkg::item_t ev;
        ev.kind       = kind;
        ev.packet_seq = pseq;
        ev.has_acks   = has_acks;
        ev.ack_start  = start;
        ev.ack_count  = count;
        ev.now        = now;
        return ev;
    endfunction

    task automatic queue_event(input dat_pkg::item_t ev);
        event_queue.push_back(ev);
        track_event(PLAN, ev);
    endtask

    task automatic plan_phase(input int n_events);
        int             made;
        int             roll;
        int             burst;
        dat_pkg::item_t ev;
        logic [15:0]    head_seq;
        logic [31:0]    due;
        made = 0;
        while (made < n_events)
        begin
            roll = $urandom_range(99);
            ev = make_event(KIND_NONE, 16'($urandom), 1'($urandom), 16'($urandom),
                            16'($urandom), $urandom);
            if (roll < 35)
            begin
                burst = ($urandom_range(9) == 0) ? $urandom_range(20, 36) : $urandom_range(1, 4);
                repeat (burst)
                begin
                    clock_ticks += 32'($urandom_range(0, 40));
                    ev.kind = dat_pkg::KIND_SEND;
                    ev.now  = clock_ticks;
                    queue_event(ev);
                    made++;
                end
            end
            else if (roll < 65)
            begin
                ev.kind = dat_pkg::KIND_RECV;
                case ($urandom_range(3))
                    0: ev.packet_seq = next_rx_seq[PLAN];
                    1: ev.packet_seq = next_rx_seq[PLAN] + 16'($urandom_range(1, 3));
                    2: ev.packet_seq = next_rx_seq[PLAN] - 16'($urandom_range(1, 3));
                    default: ;
                endcase
                head_seq = (inflight_cnt[PLAN] > 0) ? inflight_seq[PLAN][rd_ptr[PLAN]]
                                                    : next_tx_seq[PLAN];
                ev.has_acks  = ($urandom_range(9) != 0);
                ev.ack_start = head_seq + 16'($urandom_range(0, 4)) - 16'd2;
                ev.ack_count = 16'($urandom_range(0, inflight_cnt[PLAN] + 3));
                ev.now       = clock_ticks;
                queue_event(ev);
                made++;
            end
            else if (roll < 85)
            begin
                ev.kind = dat_pkg::KIND_TICK;
                clock_ticks += 32'($urandom_range(0, 60));
                ev.now = clock_ticks;
                if (inflight_cnt[PLAN] > 0)
                begin
                    due = inflight_stamp[PLAN][rd_ptr[PLAN]] + timeout_ticks[PLAN];
                    case ($urandom_range(3))
                        1: ev.now = due;
                        2: ev.now = due - 32'd1;
                        3: ev.now = $urandom;
                        default: ;
                    endcase
                end
                queue_event(ev);
                made++;
            end
            else
            begin
                ev.kind = 2'($urandom_range(3));
                queue_event(ev);
                if (ev.kind != KIND_NONE)
                begin
                    made++;
                end
            end
        end
    endtask

    task automatic wait_quiet();
        do
        begin
            @(posedge clk);
        end
        while (event_queue.size() != 0 || item_valid || awaited_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_timeout(input logic [31:0] value);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
        timeout_ticks[LIVE] = value;
        timeout_ticks[PLAN] = value;
    endtask

    always @(negedge clk)
    begin : drive_events
        dat_pkg::item_t nxt;
        logic           nxt_valid;
        nxt = drive_item;
        nxt_valid = item_valid;
        if (rst_n && (!item_valid || beat_taken))
        begin
            beat_taken = 1'b0;
            nxt_valid = 1'b0;
            if (event_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = event_queue[0];
                event_queue.delete(0);
                nxt_valid = 1'b1;
            end
        end
        drive_item <= nxt;
        item_valid <= nxt_valid;
    end

    always @(negedge clk)
    begin : drive_ready
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else if (hold_go && hold_left > 0)
        begin
            hold_left--;
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : observe
        dat_pkg::result_t want;
        bit               moved;
        moved = 1'b0;
        if (rst_n && result_ch.valid && result_ready)
        begin
            moved = 1'b1;
            beats_checked++;
            if (awaited_results.size() == 0)
            begin
                $error("result beat with status %0d arrived while nothing was expected",
                       result_ch.status);
                error_count++;
            end
            else
            begin
                want = awaited_results[0];
                awaited_results.delete(0);
                check_field("status", 32'(want.status), 32'(result_ch.status));
                check_field("result_seq", 32'(want.result_seq), 32'(result_ch.result_seq));
                check_field("last", 32'(want.last), 32'(result_ch.last));
                check_field("sent_total", want.sent_total, result_ch.sent_total);
                check_field("delivered_total", want.delivered_total,
                            result_ch.delivered_total);
                check_field("failed_total", want.failed_total, result_ch.failed_total);
                status_seen[want.status]++;
            end
        end
        if (rst_n && item_valid && item_ch.ready)
        begin
            moved = 1'b1;
            beat_taken = 1'b1;
            events_taken++;
            track_event(LIVE, drive_item);
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Watchdog: no beat on either channel for %0d cycles", QUIET_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin : run_phases
        logic [31:0] phase_timeout[6];
        int          ph;
        for (int s = 0; s < 2; s++)
        begin
            rd_ptr[s] = 0;
            wr_ptr[s] = 0;
            inflight_cnt[s] = 0;
            next_tx_seq[s] = '0;
            next_rx_seq[s] = '0;
            sent_cnt[s] = '0;
            deliv_cnt[s] = '0;
            fail_cnt[s] = '0;
            timeout_ticks[s] = dat_pkg::TIMEOUT_RESET;
        end
        for (int k = 0; k < 8; k++)
        begin
            status_seen[k] = 0;
        end
        phase_timeout[0] = 32'd0;
        phase_timeout[1] = 32'd200;
        phase_timeout[2] = 32'hFFFF_FFFF;
        phase_timeout[3] = 32'd1;
        phase_timeout[4] = 32'($urandom_range(100, 3000));
        phase_timeout[5] = 32'd1000;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_event(make_event(dat_pkg::KIND_RECV, 16'd0, 1'b0, 16'd0, 16'd0, 32'd0));
        queue_event(make_event(dat_pkg::KIND_RECV, 16'd0, 1'b0, 16'd0, 16'd0, 32'd0));
        queue_event(make_event(dat_pkg::KIND_SEND, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 32'd0));
        queue_event(make_event(dat_pkg::KIND_SEND, 16'd0, 1'b0, 16'd0, 16'd0, 32'd10));
        queue_event(make_event(dat_pkg::KIND_SEND, 16'd0, 1'b0, 16'd0, 16'd0, 32'd20));
        queue_event(make_event(dat_pkg::KIND_SEND, 16'd0, 1'b0, 16'd0, 16'd0, 32'd30));
        queue_event(make_event(dat_pkg::KIND_RECV, 16'd5, 1'b1, 16'd0, 16'd0, 32'd40));
        queue_event(make_event(dat_pkg::KIND_RECV, 16'd6, 1'b0, 16'd0, 16'd5, 32'd40));
        queue_event(make_event(dat_pkg::KIND_RECV, 16'd7, 1'b1, 16'd1, 16'd1, 32'd40));
        queue_event(make_event(dat_pkg::KIND_RECV, 16'd8, 1'b1, 16'hFFFF, 16'd2, 32'd40));
        queue_event(make_event(dat_pkg::KIND_TICK, 16'd0, 1'b0, 16'd0, 16'd0, 32'd1019));
        queue_event(make_event(dat_pkg::KIND_TICK, 16'd0, 1'b0, 16'd0, 16'd0, 32'd1020));
        queue_event(make_event(dat_pkg::KIND_SEND, 16'd0, 1'b0, 16'd0, 16'd0, 32'd1100));
        queue_event(make_event(dat_pkg::KIND_SEND, 16'd0, 1'b0, 16'd0, 16'd0, 32'd1110));
        queue_event(make_event(dat_pkg::KIND_RECV, 16'hFFFF, 1'b1, 16'd2, 16'd4, 32'd1120));
        queue_event(make_event(dat_pkg::KIND_RECV, 16'd0, 1'b1, 16'hFFFF, 16'd1, 32'd1130));
        queue_event(make_event(KIND_NONE, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
        queue_event(make_event(dat_pkg::KIND_SEND, 16'd0, 1'b0, 16'd0, 16'd0, 32'hFFFF_FFF0));
        queue_event(make_event(dat_pkg::KIND_TICK, 16'd0, 1'b0, 16'd0, 16'd0, 32'h0000_0400));
        queue_event(make_event(dat_pkg::KIND_SEND, 16'd0, 1'b0, 16'd0, 16'd0, 32'h0000_0500));
        queue_event(make_event(dat_pkg::KIND_RECV, 16'd0, 1'b1, 16'd8, 16'd1, 32'h0000_0510));
        queue_event(make_event(dat_pkg::KIND_RECV, 16'hFFFF, 1'b1, 16'd0, 16'hFFFF,
                               32'h0000_0520));
        clock_ticks = 32'h0000_0600;
        wait_quiet();

        for (ph = 0; ph < 6; ph++)
        begin
            send_idle_pct  = (ph < 2) ? 10 : (ph < 4) ? 64 : 0;
            recv_stall_pct = (ph < 2) ? 64 : (ph < 4) ? 10 : 0;
            write_timeout(phase_timeout[ph]);
            if (ph == 4)
            begin
                hold_go = 1'b1;
                repeat (36)
                begin
                    clock_ticks += 32'd3;
                    queue_event(make_event(dat_pkg::KIND_SEND, 16'($urandom), 1'($urandom),
                                           16'($urandom), 16'($urandom), clock_ticks));
                end
            end
            plan_phase(72);
            wait_quiet();
        end

        $display("Run covered %0d accepted events and %0d checked result beats",
                 events_taken, beats_checked);
        $display("over 7 timeout settings: sent %0d, refused when full %0d, delivered %0d, %s",
                 status_seen[dat_pkg::ST_SENT], status_seen[dat_pkg::ST_QFULL],
                 status_seen[dat_pkg::ST_DELIVERED],
                 $sformatf("gap failures %0d, timeouts %0d.",
                           status_seen[dat_pkg::ST_GAP_FAIL],
                           status_seen[dat_pkg::ST_TIMEOUT]));
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

>>> sim.f
src/dat_pkg.sv
src/dat_item_if.sv
src/dat_result_if.sv
src/dat_ctrl.sv
src/dat_datapath.sv
src/delivery_ack_tracker_top.sv
tb/tb_delivery_ack_tracker_top.sv
